[hdl/sra_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sra_pkg;

  typedef enum logic [1:0] {
    MODE_CLOSEST = 2'd0,
    MODE_MIN     = 2'd1,
    MODE_MAX     = 2'd2,
    MODE_AVG     = 2'd3
  } mode_t;

  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_TARGET = 1'b1;

  typedef struct packed {
    logic               record_present;
    logic [7:0]         record_type;
    logic signed [15:0] record_value;
    logic [15:0]        record_distance;
    logic               last_record;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] result_value;
    logic               found;
  } out_result_t;

endpackage

`default_nettype wire

[hdl/sensor_reading_aggregator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Closest, minimum and maximum results are registered from the item in stage two that
// closes the batch; an average result with matches is produced by the bit-serial divider.
// Throughput: one record per cycle through the read-modify-write of the state memory,
// while busy is low; busy is high while a closing average item is in stage two and while
// the divider runs, and start is not accepted then.
// Reset (rst_n, synchronous) clears the registers, the control state and the batch state.
module sensor_reading_aggregator #(
  parameter int MAX_RECORDS = 64
) (
  input  wire                      clk,
  input  wire                      rst_n,

  input  wire                      start,
  output logic                     busy,
  input  wire sra_pkg::in_item_t   in_item,

  output logic                     out_strobe,
  output sra_pkg::out_result_t     out_result,

  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire  [2:0]               paddr,
  input  wire  [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int CW   = $clog2(MAX_RECORDS + 1);
  localparam int SW   = 16 + CW;
  localparam int DCW  = $clog2(SW + 1);

  typedef struct packed {
    logic [CW-1:0]        records_seen;
    logic [CW-1:0]        match_count;
    logic signed [15:0]   best_value;
    logic [15:0]          best_distance;
    logic signed [SW-1:0] running_sum;
  } state_t;

  sra_pkg::mode_t       mode_r;
  logic [7:0]           target_type_r;

  logic                 s2_valid_r;
  sra_pkg::in_item_t    s2_item_r;

  state_t               state_mem [1];
  state_t               rd_state_r;
  logic                 mem_valid_r;
  state_t               wb_r;
  logic                 wb_hit_r;

  state_t               cur_state;
  state_t               upd_state;
  state_t               wr_state;

  logic                 div_active_r;
  logic [DCW-1:0]       div_cnt_r;
  logic [CW-1:0]        div_rem_r;
  logic [SW-1:0]        div_quo_r;
  logic [CW-1:0]        div_den_r;
  logic                 div_neg_r;
  logic [CW:0]          div_trial;
  logic                 div_take;
  logic [CW-1:0]        div_rem_nxt;
  logic [SW-1:0]        div_quo_nxt;
  logic [15:0]          div_mag;

  logic                 out_strobe_r;
  sra_pkg::out_result_t out_result_r;

  logic                 cfg_write;
  logic                 accept;
  logic                 close_batch;
  logic                 start_div;
  logic [SW-1:0]        sum_mag;

  assign cfg_write = psel & penable & pwrite & pready;
  assign pready    = 1'b1;

  always_comb begin
    if (paddr[2] == sra_pkg::REG_TARGET) begin
      prdata = {24'd0, target_type_r};
    end else begin
      prdata = {30'd0, mode_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= sra_pkg::MODE_CLOSEST;
      target_type_r <= 8'd0;
    end else if (cfg_write) begin
      if (paddr[2] == sra_pkg::REG_TARGET) begin
        target_type_r <= pwdata[7:0];
      end else begin
        mode_r <= sra_pkg::mode_t'(pwdata[1:0]);
      end
    end
  end

  assign busy   = div_active_r |
                  (s2_valid_r & s2_item_r.last_record & (mode_r == sra_pkg::MODE_AVG));
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_item_r <= in_item;
    end
  end

  // Single-entry state memory: read every cycle, written back by the item in stage two.
  always_ff @(posedge clk) begin
    rd_state_r <= state_mem[0];
    if (s2_valid_r) begin
      state_mem[0] <= wr_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_valid_r <= 1'b0;
      wb_hit_r    <= 1'b0;
    end else begin
      wb_hit_r <= s2_valid_r;
      if (s2_valid_r) begin
        mem_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      wb_r <= wr_state;
    end
  end

  // A write in the previous cycle is not yet visible in the read data, so it is forwarded.
  always_comb begin
    if (wb_hit_r) begin
      cur_state = wb_r;
    end else if (mem_valid_r) begin
      cur_state = rd_state_r;
    end else begin
      cur_state = '0;
    end
  end

  always_comb begin
    upd_state = cur_state;
    if (s2_item_r.record_present && (cur_state.records_seen < CW'(MAX_RECORDS))) begin
      upd_state.records_seen = cur_state.records_seen + 1'b1;
      if (s2_item_r.record_type == target_type_r) begin
        case (mode_r)
          sra_pkg::MODE_CLOSEST: begin
            if ((cur_state.match_count == '0) ||
                (s2_item_r.record_distance < cur_state.best_distance)) begin
              upd_state.best_value    = s2_item_r.record_value;
              upd_state.best_distance = s2_item_r.record_distance;
            end
          end
          sra_pkg::MODE_MIN: begin
            if ((cur_state.match_count == '0) ||
                (s2_item_r.record_value < cur_state.best_value)) begin
              upd_state.best_value = s2_item_r.record_value;
            end
          end
          sra_pkg::MODE_MAX: begin
            if ((cur_state.match_count == '0) ||
                (s2_item_r.record_value > cur_state.best_value)) begin
              upd_state.best_value = s2_item_r.record_value;
            end
          end
          default: begin
          end
        endcase
        upd_state.running_sum = cur_state.running_sum +
                                {{(SW-16){s2_item_r.record_value[15]}}, s2_item_r.record_value};
        upd_state.match_count = cur_state.match_count + 1'b1;
      end
    end
  end

  assign close_batch = s2_valid_r & s2_item_r.last_record;
  assign wr_state    = s2_item_r.last_record ? '0 : upd_state;
  assign start_div   = close_batch & (mode_r == sra_pkg::MODE_AVG) &
                       (upd_state.match_count != '0);
  assign sum_mag     = upd_state.running_sum[SW-1] ? SW'(-upd_state.running_sum) :
                                                     SW'(upd_state.running_sum);

  // Restoring divider on magnitudes, one quotient bit per cycle.
  always_comb begin
    div_trial   = {div_rem_r, div_quo_r[SW-1]};
    div_take    = (div_trial >= {1'b0, div_den_r});
    div_rem_nxt = div_take ? CW'(div_trial - {1'b0, div_den_r}) : div_trial[CW-1:0];
    div_quo_nxt = {div_quo_r[SW-2:0], div_take};
    div_mag     = div_neg_r ? 16'(-div_quo_nxt[15:0]) : div_quo_nxt[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_active_r <= 1'b0;
      div_cnt_r    <= '0;
    end else if (start_div) begin
      div_active_r <= 1'b1;
      div_cnt_r    <= DCW'(SW);
    end else if (div_active_r) begin
      div_cnt_r <= div_cnt_r - 1'b1;
      if (div_cnt_r == DCW'(1)) begin
        div_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_div) begin
      div_rem_r <= '0;
      div_quo_r <= sum_mag;
      div_den_r <= upd_state.match_count;
      div_neg_r <= upd_state.running_sum[SW-1];
    end else if (div_active_r) begin
      div_rem_r <= div_rem_nxt;
      div_quo_r <= div_quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (close_batch & ~start_div) | (div_active_r & (div_cnt_r == DCW'(1)));
    end
  end

  always_ff @(posedge clk) begin
    if (div_active_r && (div_cnt_r == DCW'(1))) begin
      out_result_r.result_value <= div_mag;
      out_result_r.found        <= 1'b1;
    end else if (close_batch) begin
      out_result_r.found <= (upd_state.match_count != '0);
      if ((upd_state.match_count != '0) && (mode_r != sra_pkg::MODE_AVG)) begin
        out_result_r.result_value <= upd_state.best_value;
      end else begin
        out_result_r.result_value <= 16'sd0;
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

endmodule

`default_nettype wire
